/* hdl/rrss_pkg.sv */
package rrss_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int TW = 21;
	localparam int DW = 16;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STEP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_SLICE    = 3'd0,
		ST_IDLETICK = 3'd1,
		ST_ALLDONE  = 3'd2,
		ST_LOADED   = 3'd3,
		ST_REJECTED = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_CHECK,
		S_PASS,
		S_RUN,
		S_ADVT,
		S_TAT,
		S_WAIT,
		S_TICK
	} state_t;

	typedef struct packed {
		logic [DW-1:0] arrival;
		logic [DW-1:0] burst;
		logic [DW-1:0] remaining;
		logic [TW-1:0] response;
	} entry_t;

	typedef struct packed {
		status_t       status;
		logic [3:0]    index;
		logic [TW-1:0] start;
		logic [TW-1:0] stop;
		logic          fin;
		logic [TW-1:0] waiting;
		logic [TW-1:0] turnaround;
		logic [TW-1:0] response;
	} res_t;

	function automatic res_t mk_res(
		input status_t       status,
		input logic [3:0]    index,
		input logic [TW-1:0] start,
		input logic [TW-1:0] stop,
		input logic          fin,
		input logic [TW-1:0] waiting,
		input logic [TW-1:0] turnaround,
		input logic [TW-1:0] response
	);
		res_t r;
		r.status     = status;
		r.index      = index;
		r.start      = start;
		r.stop       = stop;
		r.fin        = fin;
		r.waiting    = waiting;
		r.turnaround = turnaround;
		r.response   = response;
		return r;
	endfunction

endpackage

/* hdl/round_robin_slice_scheduler_top.sv */
// round-robin slice scheduler: process entries (arrival, burst) are loaded into
// a table of MAX_PROCS entries, and each step item hands out one time slice
// of at most quantum units to the next ready entry in index order, an idle
// tick when a whole pass finds nobody ready, or all done. an item is taken
// when start is high and busy is low; exactly one result follows for load,
// step and clear (op three is ignored), shown for a single cycle under
// strobe, and the receiver cannot hold it off, so capture it on that cycle.
// load and clear answer at once: the result is registered and shows in the next cycle. a step
// walks the table one entry per cycle through a single shared
// add/subtract unit and one table read port: it fetches, checks entries in turn,
// runs the slice and advances time, then works out turnaround and waiting when
// the slice finishes the process; a pass wraps back to entry 0 at most once.
// an all-done step answers straight from idle. quantum is written
// through the cfg channel, always ready; write it only while busy is low
// and no result is pending. a quantum of zero acts as one.
module round_robin_slice_scheduler_top #(
	parameter int MAX_PROCS = rrss_pkg::MAX_PROCS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [rrss_pkg::DW-1:0] arrival_time,
	input  logic [rrss_pkg::DW-1:0] burst_time,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [rrss_pkg::DW-1:0] cfg_data,
	output logic                    strobe,
	output logic [2:0]              status,
	output logic [3:0]              process_index,
	output logic [rrss_pkg::TW-1:0] slice_start,
	output logic [rrss_pkg::TW-1:0] slice_end,
	output logic                    finished,
	output logic [rrss_pkg::TW-1:0] waiting_time,
	output logic [rrss_pkg::TW-1:0] turnaround_time,
	output logic [rrss_pkg::TW-1:0] response_time
);
	import rrss_pkg::*;

	// index into the table, and a pointer that can also hold the count itself
	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PW = $clog2(MAX_PROCS + 1);

	// control state
	state_t               state_q, state_d;
	logic [DW-1:0]        quantum_q;
	logic [PW-1:0]        loaded_q;
	logic [PW-1:0]        completed_q;
	logic [TW-1:0]        time_q;
	logic [PW-1:0]        sptr_q;
	logic                 served_q;
	logic [MAX_PROCS-1:0] started_q;
	logic                 strobe_q;

	// scan and slice working registers
	logic [PW-1:0]        idx_q;
	logic [PW-1:0]        cidx_q;
	entry_t               rd_q;
	logic [TW-1:0]        resp_cand_q;
	logic [TW-1:0]        start_time_q;
	logic [DW-1:0]        run_q;
	logic [DW-1:0]        rem_q;
	logic [TW-1:0]        resp_q;
	logic [TW-1:0]        tat_q;
	res_t                 res_q;

	// the process table
	entry_t               mem [MAX_PROCS];

	// shared add/subtract unit
	logic [TW-1:0]        alu_a, alu_b;
	logic                 alu_sub;
	logic [TW:0]          alu_r;
	logic                 alu_c;

	logic                 hit;
	logic                 rd_en;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	entry_t               wr_data;
	logic [DW-1:0]        qeff;
	logic                 accept;
	logic                 all_done;
	logic                 load_rej;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign all_done  = (completed_q >= loaded_q);
	assign load_rej  = (burst_time == '0) || (loaded_q >= PW'(MAX_PROCS));
	assign qeff      = (quantum_q == '0) ? DW'(1) : quantum_q;

	// a - b sets the top bit when a >= b; a + b for time advance
	assign alu_r = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (TW+1)'(alu_sub);
	assign alu_c = alu_r[TW];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op_t'(op) == OP_STEP && !all_done) begin
					state_d = (sptr_q >= loaded_q) ? S_PASS : S_FETCH;
				end
			end
			S_FETCH: state_d = S_CHECK;
			S_CHECK: begin
				if (hit) begin
					state_d = S_RUN;
				end else if (idx_q >= loaded_q) begin
					state_d = S_PASS;
				end
			end
			// end of the table: restart from entry 0 once if this pass served someone
			S_PASS:  state_d = served_q ? S_FETCH : S_TICK;
			S_RUN:   state_d = S_ADVT;
			S_ADVT:  state_d = (rem_q == '0) ? S_TAT : S_IDLE;
			S_TAT:   state_d = S_WAIT;
			S_WAIT:  state_d = S_IDLE;
			S_TICK:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// alu operands, table read and write control
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		hit     = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = loaded_q[IW-1:0];
		wr_data = '{arrival: arrival_time, burst: burst_time, remaining: burst_time,
			response: '0};
		unique case (state_q)
			S_IDLE: begin
				wr_en = accept && op_t'(op) == OP_LOAD && !load_rej;
			end
			S_FETCH: begin
				rd_en = 1'b1;
			end
			S_CHECK: begin
				// ready: arrived by now and burst not used up
				alu_a = time_q;
				alu_b = TW'(rd_q.arrival);
				hit   = alu_c && (rd_q.remaining != '0);
				rd_en = !hit;
			end
			S_RUN: begin
				// remaining - quantum: carry picks the slice length
				alu_a   = TW'(rd_q.remaining);
				alu_b   = TW'(qeff);
				wr_en   = 1'b1;
				wr_addr = cidx_q[IW-1:0];
				wr_data.arrival   = rd_q.arrival;
				wr_data.burst     = rd_q.burst;
				wr_data.remaining = alu_c ? alu_r[DW-1:0] : '0;
				wr_data.response  = started_q[cidx_q[IW-1:0]] ? rd_q.response : resp_cand_q;
			end
			S_ADVT: begin
				alu_a   = time_q;
				alu_b   = TW'(run_q);
				alu_sub = 1'b0;
			end
			S_TAT: begin
				alu_a = time_q;
				alu_b = TW'(rd_q.arrival);
			end
			S_WAIT: begin
				alu_a = tat_q;
				alu_b = TW'(rd_q.burst);
			end
			S_TICK: begin
				alu_a   = time_q;
				alu_b   = TW'(1);
				alu_sub = 1'b0;
			end
			default: begin
				alu_sub = 1'b1;
			end
		endcase
	end

	// table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q[IW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quantum_q   <= DW'(1);
			loaded_q    <= '0;
			completed_q <= '0;
			time_q      <= '0;
			sptr_q      <= '0;
			served_q    <= 1'b0;
			started_q   <= '0;
			strobe_q    <= 1'b0;
			idx_q       <= '0;
			cidx_q      <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op_t'(op))
							OP_LOAD: begin
								strobe_q <= 1'b1;
								if (!load_rej) begin
									started_q[loaded_q[IW-1:0]] <= 1'b0;
									loaded_q                    <= loaded_q + 1'b1;
								end
							end
							OP_STEP: begin
								strobe_q <= all_done;
								idx_q    <= sptr_q;
							end
							OP_CLEAR: begin
								strobe_q    <= 1'b1;
								loaded_q    <= '0;
								completed_q <= '0;
								time_q      <= '0;
								sptr_q      <= '0;
								served_q    <= 1'b0;
								started_q   <= '0;
							end
							OP_NONE: begin
								strobe_q <= 1'b0;
							end
							default: begin
								strobe_q <= 1'b0;
							end
						endcase
					end
				end
				S_FETCH: begin
					cidx_q <= idx_q;
					idx_q  <= idx_q + 1'b1;
				end
				S_CHECK: begin
					if (!hit && idx_q < loaded_q) begin
						cidx_q <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end
				end
				S_PASS: begin
					if (served_q) begin
						served_q <= 1'b0;
						sptr_q   <= '0;
						idx_q    <= '0;
					end
				end
				S_RUN: begin
					started_q[cidx_q[IW-1:0]] <= 1'b1;
					sptr_q                    <= cidx_q + 1'b1;
					served_q                  <= 1'b1;
				end
				S_ADVT: begin
					time_q   <= alu_r[TW-1:0];
					strobe_q <= (rem_q != '0);
				end
				S_TAT: begin
					strobe_q <= 1'b0;
				end
				S_WAIT: begin
					strobe_q    <= 1'b1;
					completed_q <= completed_q + 1'b1;
				end
				S_TICK: begin
					strobe_q <= 1'b1;
					time_q   <= alu_r[TW-1:0];
					sptr_q   <= '0;
					served_q <= 1'b0;
				end
				default: begin
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	// slice datapath and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && op_t'(op) == OP_LOAD) begin
					if (load_rej) begin
						res_q <= mk_res(ST_REJECTED, '0, '0, '0, 1'b0, '0, '0, '0);
					end else begin
						res_q <= mk_res(ST_LOADED, 4'(loaded_q), '0, '0, 1'b0, '0, '0, '0);
					end
				end else if (accept && op_t'(op) == OP_STEP) begin
					res_q <= mk_res(ST_ALLDONE, '0, time_q, time_q, 1'b0, '0, '0, '0);
				end else if (accept && op_t'(op) == OP_CLEAR) begin
					res_q <= mk_res(ST_CLEARED, '0, '0, '0, 1'b0, '0, '0, '0);
				end
			end
			S_CHECK: begin
				if (hit) begin
					resp_cand_q  <= alu_r[TW-1:0];
					start_time_q <= time_q;
				end
			end
			S_RUN: begin
				run_q  <= alu_c ? qeff : rd_q.remaining;
				rem_q  <= wr_data.remaining;
				resp_q <= wr_data.response;
			end
			S_ADVT: begin
				res_q <= mk_res(ST_SLICE, 4'(cidx_q), start_time_q, alu_r[TW-1:0], 1'b0,
					'0, '0, resp_q);
			end
			S_TAT: begin
				tat_q <= alu_r[TW-1:0];
			end
			S_WAIT: begin
				res_q <= mk_res(ST_SLICE, 4'(cidx_q), start_time_q, time_q, 1'b1,
					alu_r[TW-1:0], tat_q, resp_q);
			end
			S_TICK: begin
				res_q <= mk_res(ST_IDLETICK, '0, time_q, alu_r[TW-1:0], 1'b0, '0, '0, '0);
			end
			default: begin
				tat_q <= tat_q;
			end
		endcase
	end

	assign strobe          = strobe_q;
	assign status          = res_q.status;
	assign process_index   = res_q.index;
	assign slice_start     = res_q.start;
	assign slice_end       = res_q.stop;
	assign finished        = res_q.fin;
	assign waiting_time    = res_q.waiting;
	assign turnaround_time = res_q.turnaround;
	assign response_time   = res_q.response;

`ifndef SYNTH
	// a result only goes out as the sequencer returns to idle
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> state_q == S_IDLE)
		else $error("result strobe while sequencer busy");

	// never more completions than loaded entries
	a_completed: assert property (@(posedge clk) disable iff (!arst_n)
		completed_q <= loaded_q)
		else $error("completed count above loaded count");

	// the resume point never runs past the table fill
	a_sptr: assert property (@(posedge clk) disable iff (!arst_n)
		sptr_q <= loaded_q)
		else $error("scan pointer beyond loaded entries");

	// a slice always moves time forward
	a_slice_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && res_q.status == ST_SLICE) |-> res_q.stop != res_q.start)
		else $error("empty slice reported");

	// a hit always leads to a write back of that entry
	a_hit_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && hit) |=> (state_q == S_RUN && wr_en))
		else $error("ready entry not written back");
`endif

endmodule
